@@ design/mpd_pkg.sv @@
// Package for the MIDI packet decoder: command codes, message kinds,
// configuration and decode-result types. No dependencies.

package mpd_pkg;

    // Command codes carried in the result.
    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_NOTE_ON    = 4'd1,
        CMD_NOTE_OFF   = 4'd2,
        CMD_BEND       = 4'd3,
        CMD_CH_PRESS   = 4'd4,
        CMD_POLY_PRESS = 4'd5,
        CMD_PEDAL      = 4'd6,
        CMD_ALL_OFF    = 4'd7,
        CMD_RESET      = 4'd8
    } cmd_t;

    // Upper nibble of the MIDI status byte.
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
    localparam logic [3:0] KIND_CONTROL    = 4'hB;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CH_PRESS   = 4'hD;
    localparam logic [3:0] KIND_BEND       = 4'hE;
    localparam logic [3:0] KIND_SYSTEM     = 4'hF;

    // Controller numbers with a meaning of their own.
    localparam logic [6:0] CTL_SUSTAIN    = 7'd64;
    localparam logic [6:0] CTL_SOSTENUTO  = 7'd66;
    localparam logic [6:0] CTL_SOFT       = 7'd67;
    localparam logic [6:0] CTL_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CTL_RESET_CTLS = 7'd121;
    localparam logic [6:0] CTL_NOTES_OFF  = 7'd123;

    // Pedal selections.
    localparam logic [1:0] PEDAL_NONE      = 2'd0;
    localparam logic [1:0] PEDAL_SUSTAIN   = 2'd1;
    localparam logic [1:0] PEDAL_SOSTENUTO = 2'd2;
    localparam logic [1:0] PEDAL_SOFT      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_CHANNEL_SELECT   = 3'd0;
    localparam logic [2:0] REG_BEND_ENABLE      = 3'd1;
    localparam logic [2:0] REG_PRESSURE_ENABLE  = 3'd2;
    localparam logic [2:0] REG_ALL_OFF_ENABLE   = 3'd3;
    localparam logic [2:0] REG_RESET_CTL_ENABLE = 3'd4;

    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;
    localparam int COUNT_W    = 32;

    // Current configuration.
    typedef struct packed {
        logic [4:0] channel_select;
        logic       bend_enable;
        logic       pressure_enable;
        logic       all_off_enable;
        logic       reset_ctl_enable;
    } cfg_t;

    // One input packet.
    typedef struct packed {
        logic [7:0] second_data;
        logic [7:0] first_data;
        logic [7:0] status_byte;
        logic [7:0] packet_header;
    } packet_t;

    // Decoded result without the running counts.
    typedef struct packed {
        cmd_t        command;
        logic [6:0]  key_number;
        logic [6:0]  amount;
        logic [1:0]  pedal_select;
        logic [13:0] bend_value;
        logic        bad_packet;
        logic        counted;
    } decoded_t;

endpackage

@@ design/mpd_in_stage.sv @@
// Input register of the MIDI packet decoder: takes one packet per
// transaction and holds it for the decode logic. Depends on mpd_pkg.

module mpd_in_stage
    import mpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_DATA_W-1:0] s_data,
    output logic                 held_valid,
    input  logic                 held_take,
    output packet_t              held_packet
);

    logic    valid_reg;
    logic    valid_next;
    packet_t packet_reg;

    // The stage can load when it is empty or its packet leaves this cycle.
    assign s_ready    = !valid_reg || held_take;
    assign valid_next = (valid_reg && !held_take) || s_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Packet payload, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            packet_reg <= packet_t'(s_data);
        end
    end

    assign held_valid  = valid_reg;
    assign held_packet = packet_reg;

endmodule

@@ design/mpd_decode.sv @@
// Combinational decode of one USB MIDI event packet into a command.
// Depends on mpd_pkg.

module mpd_decode
    import mpd_pkg::*;
(
    input  packet_t  packet,
    input  cfg_t     cfg,
    output decoded_t result
);

    logic [3:0] kind;
    logic [3:0] chan;
    logic [6:0] d1;
    logic [6:0] d2;
    logic       valid_pkt;
    logic       chan_match;
    logic [4:0] chan_plus_one;

    assign kind = packet.status_byte[7:4];
    assign chan = packet.status_byte[3:0];
    assign d1   = packet.first_data[6:0];
    assign d2   = packet.second_data[6:0];

    // Validation: status byte, data bytes the kind uses at most 127.
    always_comb
    begin
        unique case (kind)
            KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS, KIND_CONTROL, KIND_BEND:
                valid_pkt = !packet.first_data[7] && !packet.second_data[7];
            KIND_PROGRAM, KIND_CH_PRESS:
                valid_pkt = !packet.first_data[7];
            KIND_SYSTEM:
                valid_pkt = 1'b1;
            default:
                valid_pkt = 1'b0;
        endcase
    end

    // Channel filter: zero passes all, otherwise channel number plus one.
    assign chan_plus_one = {1'b0, chan} + 5'd1;
    assign chan_match    = (cfg.channel_select == 5'd0) ||
                           (cfg.channel_select == chan_plus_one);

    // Command decode; unused fields stay at zero.
    always_comb
    begin
        result              = '0;
        result.command      = CMD_NONE;
        result.counted      = (packet.packet_header != 8'd0);
        result.bad_packet   = result.counted && !valid_pkt;
        if (result.counted && valid_pkt && chan_match)
        begin
            unique case (kind)
                KIND_NOTE_ON:
                begin
                    result.key_number = d1;
                    if (d2 != 7'd0)
                    begin
                        result.command = CMD_NOTE_ON;
                        result.amount  = d2;
                    end
                    else
                    begin
                        result.command = CMD_NOTE_OFF;
                    end
                end
                KIND_NOTE_OFF:
                begin
                    result.command    = CMD_NOTE_OFF;
                    result.key_number = d1;
                end
                KIND_BEND:
                begin
                    if (cfg.bend_enable)
                    begin
                        result.command    = CMD_BEND;
                        result.bend_value = {d2, d1};
                    end
                end
                KIND_CH_PRESS:
                begin
                    if (cfg.pressure_enable)
                    begin
                        result.command = CMD_CH_PRESS;
                        result.amount  = d1;
                    end
                end
                KIND_POLY_PRESS:
                begin
                    if (cfg.pressure_enable)
                    begin
                        result.command    = CMD_POLY_PRESS;
                        result.key_number = d1;
                        result.amount     = d2;
                    end
                end
                KIND_CONTROL:
                begin
                    if (d1 == CTL_SUSTAIN || d1 == CTL_SOSTENUTO || d1 == CTL_SOFT)
                    begin
                        result.command      = CMD_PEDAL;
                        result.amount       = d2;
                        result.pedal_select = (d1 == CTL_SUSTAIN)   ? PEDAL_SUSTAIN :
                                              (d1 == CTL_SOSTENUTO) ? PEDAL_SOSTENUTO :
                                                                      PEDAL_SOFT;
                    end
                    else if (d1 == CTL_SOUND_OFF || d1 == CTL_NOTES_OFF)
                    begin
                        if (cfg.all_off_enable)
                        begin
                            result.command = CMD_ALL_OFF;
                        end
                    end
                    else if (d1 == CTL_RESET_CTLS)
                    begin
                        if (cfg.reset_ctl_enable)
                        begin
                            result.command = CMD_RESET;
                        end
                    end
                end
                default:
                begin
                    result.command = CMD_NONE;
                end
            endcase
        end
    end

endmodule

@@ design/mpd_out_stage.sv @@
// Result register and running packet counters of the MIDI packet decoder.
// Depends on mpd_pkg.

module mpd_out_stage
    import mpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  decoded_t            load_result,
    output logic                m_valid,
    input  logic                m_ready,
    output decoded_t            out_result,
    output logic [COUNT_W-1:0]  seen_count,
    output logic [COUNT_W-1:0]  bad_count
);

    logic               valid_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [COUNT_W-1:0] bad_reg;
    logic [COUNT_W-1:0] bad_next;
    decoded_t           result_reg;
    logic               load;

    assign load_ready = !valid_reg || m_ready;
    assign load       = load_valid && load_ready;

    // The counters advance with the transaction that enters the register,
    // so they always match the result on show.
    assign seen_next = seen_reg + COUNT_W'(load_result.counted);
    assign bad_next  = bad_reg + COUNT_W'(load_result.bad_packet);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= '0;
            bad_reg   <= '0;
        end
        else
        begin
            if (load_ready)
            begin
                valid_reg <= load_valid;
            end
            if (load)
            begin
                seen_reg <= seen_next;
                bad_reg  <= bad_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign m_valid    = valid_reg;
    assign out_result = result_reg;
    assign seen_count = seen_reg;
    assign bad_count  = bad_reg;

endmodule

@@ design/midi_packet_decoder.sv @@
// Top level of the USB MIDI event packet decoder.
// Depends on mpd_pkg, mpd_in_stage, mpd_decode and mpd_out_stage.
//
// One four-byte USB MIDI event packet enters per clock while the result
// side accepts, and every packet gives exactly one result: an input
// register holds the packet, the decode logic and the counter increment
// sit between it and the result register. Sustained rate is one packet
// per cycle, set by the two-register pipeline; back-pressure on the result
// side reaches the input through the stage enables. The result carries the
// decoded command, the bad-packet flag (tuser) and the running counts of
// nonzero-header and invalid packets after this one. Configuration writes
// take effect at once and are meant for idle periods.

module midi_packet_decoder
    import mpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Packet input.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // packet_header[7:0], status_byte[15:8], first_data[23:16], second_data[31:24]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result output.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // command[3:0], key_number[10:4], amount[17:11], pedal_select[19:18],
    // bend_value[33:20], packets_seen[65:34], packets_bad[97:66], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // bad_packet[0]
    output logic                  m_axis_tuser
);

    cfg_t               cfg_reg;
    logic               held_valid;
    logic               held_take;
    packet_t            held_packet;
    decoded_t           decoded;
    decoded_t           out_result;
    logic [COUNT_W-1:0] seen_count;
    logic [COUNT_W-1:0] bad_count;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_select   <= 5'd0;
            cfg_reg.bend_enable      <= 1'b1;
            cfg_reg.pressure_enable  <= 1'b1;
            cfg_reg.all_off_enable   <= 1'b1;
            cfg_reg.reset_ctl_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHANNEL_SELECT:   cfg_reg.channel_select   <= cfg_data;
                REG_BEND_ENABLE:      cfg_reg.bend_enable      <= cfg_data[0];
                REG_PRESSURE_ENABLE:  cfg_reg.pressure_enable  <= cfg_data[0];
                REG_ALL_OFF_ENABLE:   cfg_reg.all_off_enable   <= cfg_data[0];
                REG_RESET_CTL_ENABLE: cfg_reg.reset_ctl_enable <= cfg_data[0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    mpd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .held_valid  (held_valid),
        .held_take   (held_take),
        .held_packet (held_packet)
    );

    // Decode logic.
    mpd_decode u_decode (
        .packet (held_packet),
        .cfg    (cfg_reg),
        .result (decoded)
    );

    // Result register and counters.
    mpd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (held_valid),
        .load_ready  (held_take),
        .load_result (decoded),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .out_result  (out_result),
        .seen_count  (seen_count),
        .bad_count   (bad_count)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = {6'd0, bad_count, seen_count, out_result.bend_value,
                           out_result.pedal_select, out_result.amount,
                           out_result.key_number, out_result.command};
    assign m_axis_tuser = out_result.bad_packet;

endmodule
